// ----- hw/rtl/fedg_pkg.sv -----
// Shared types and constants for the far-end duck gain with volume block.
// Used by every module of the block; depends on nothing.
package fedg_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int STEP_W     = 15;
   localparam int VOLUME_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_FRAC  = 15;
   localparam int VOL_FRAC   = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [GAIN_W-1:0]          GAIN_UNITY = 16'h7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   localparam logic [STEP_W-1:0]   STEP_UP_RESET    = 15'd64;
   localparam logic [STEP_W-1:0]   STEP_DOWN_RESET  = 15'd64;
   localparam logic [STEP_W-1:0]   GAIN_FLOOR_RESET = 15'd0;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET     = 16'd1024;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP_UP    = 3'd0,
      CSR_STEP_DOWN  = 3'd1,
      CSR_GAIN_FLOOR = 3'd2,
      CSR_VOLUME     = 3'd3,
      CSR_BYPASS     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step_up;
      logic [STEP_W-1:0]   step_down;
      logic [STEP_W-1:0]   gain_floor;
      logic [VOLUME_W-1:0] volume_q10;
      logic                bypass;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [STEP_W-1:0]          gain;
      logic                       scale;
      logic                       vol_en;
   } entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic              s1_valid;
   } back_status_type;

endpackage

// ----- hw/rtl/fedg_front.sv -----
// Front end: takes items, updates the duck gain and the volume enable latch.
// Depends on fedg_pkg; builds the queue entry that the top level pushes for each item.
module fedg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  fedg_pkg::cfg_type           cfg,
   input  logic                        accept,
   input  logic signed [15:0]          sample_in,
   input  logic                        duck,
   input  logic                        frame_start,
   output fedg_pkg::entry_type         entry,
   output logic [15:0]                 gain
);
   import fedg_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              vol_en_ff, vol_en_in;
   logic [GAIN_W-1:0] floor_ext, step_dn_ext;
   logic [GAIN_W:0]   sum;
   logic              above_floor;

   assign floor_ext   = {1'b0, cfg.gain_floor};
   assign step_dn_ext = {1'b0, cfg.step_down};
   assign above_floor = floor_ext < gain_ff;
   assign sum         = {1'b0, gain_ff} + {2'b00, cfg.step_up};

   always_comb begin
      vol_en_in = vol_en_ff;
      if (frame_start) begin
         vol_en_in = cfg.bypass || !duck || above_floor;
      end
      gain_in = gain_ff;
      priority if (cfg.bypass) begin
         gain_in = gain_ff;
      end else if (duck) begin
         if (above_floor) begin
            gain_in = ((gain_ff - floor_ext) <= step_dn_ext) ? floor_ext
                                                           : gain_ff - step_dn_ext;
         end
      end else if (gain_ff != GAIN_UNITY) begin
         gain_in = (sum > {1'b0, GAIN_UNITY}) ? GAIN_UNITY : sum[GAIN_W-1:0];
      end else begin
         gain_in = gain_ff;
      end
   end

   always_comb begin
      entry.sample = sample_in;
      entry.gain   = gain_ff[STEP_W-1:0];
      entry.scale  = !cfg.bypass && (duck || gain_ff != GAIN_UNITY);
      entry.vol_en = vol_en_in;
   end

   assign gain = gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         vol_en_ff <= 1'b0;
      end else if (accept) begin
         gain_ff   <= gain_in;
         vol_en_ff <= vol_en_in;
      end
   end

endmodule

// ----- hw/rtl/fedg_queue.sv -----
// Short entry queue between front and back end.
// Depends on fedg_pkg for the entry type and depth.
module fedg_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  fedg_pkg::entry_type           push_entry,
   input  logic                          pop,
   output fedg_pkg::entry_type           head,
   output fedg_pkg::queue_status_type    status
);
   import fedg_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- hw/rtl/fedg_back.sv -----
// Back end: gain multiply stage, then volume multiply, saturate and output register.
// Depends on fedg_pkg; drains the entry queue.
module fedg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  fedg_pkg::cfg_type           cfg,
   input  fedg_pkg::entry_type         head,
   input  logic                        head_valid,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [15:0]          out_sample,
   output logic                        out_vol_used,
   output fedg_pkg::back_status_type   status
);
   import fedg_pkg::*;

   logic                          s1_valid_ff;
   logic signed [SAMPLE_W-1:0]    s1_sample_ff, s1_sample_in;
   logic                          s1_vol_en_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_W-1:0]    out_sample_ff, out_sample_in;
   logic                          out_vol_ff;
   logic                          out_free, s1_free, s1_move;
   logic signed [31:0]            gain_prod;
   logic signed [32:0]            vol_prod;
   logic signed [22:0]            vol_shift;

   assign out_free = !out_valid_ff || out_ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head_valid && s1_free;

   assign gain_prod    = head.sample * $signed({1'b0, head.gain});
   assign s1_sample_in = head.scale ? gain_prod[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC]
                                    : head.sample;

   assign vol_prod  = s1_sample_ff * $signed({1'b0, cfg.volume_q10});
   assign vol_shift = vol_prod[32:VOL_FRAC];

   always_comb begin
      priority if (!s1_vol_en_ff) begin
         out_sample_in = s1_sample_ff;
      end else if (vol_shift > 23'(SAMPLE_MAX)) begin
         out_sample_in = SAMPLE_MAX;
      end else if (vol_shift < 23'(SAMPLE_MIN)) begin
         out_sample_in = SAMPLE_MIN;
      end else begin
         out_sample_in = vol_shift[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_sample_ff <= s1_sample_in;
         s1_vol_en_ff <= head.vol_en;
      end
      if (s1_move) begin
         out_sample_ff <= out_sample_in;
         out_vol_ff    <= s1_vol_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= pop;
         end
         if (out_free) begin
            out_valid_ff <= s1_move;
         end
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_sample      = out_sample_ff;
   assign out_vol_used    = out_vol_ff;
   assign status.s1_valid = s1_valid_ff;

endmodule

// ----- hw/rtl/far_end_duck_gain_with_volume.sv -----
// Top level of the far-end duck gain with volume block: registers, front, queue, back.
// Depends on fedg_pkg, fedg_front, fedg_queue and fedg_back.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/req_tready  tdata sample_in, tuser duck, frame_start
//   rsp      out        rsp_tvalid/rsp_tready  tdata sample_out, tuser volume_used
//   csr      in         csr_we                 csr_addr, csr_wdata
//
// One item per cycle sustained while rsp_tready is high; an item goes from its queue slot
// to the gain multiply register and then to the volume multiply output register that drives rsp.
// Synchronous reset: gain to zero, volume enable off, registers to defaults, queue empty.
// req_tready drops only when the four-entry queue is full; a stalled rsp backs up
// through the two multiply registers into the queue.
module far_end_duck_gain_with_volume (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   input  logic [1:0]  req_tuser,   // [0] duck, [1] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   output logic        rsp_tuser,   // [0] volume_used
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import fedg_pkg::*;

   cfg_type          cfg_ff;
   entry_type        push_entry, head;
   queue_status_type q_status;
   back_status_type  b_status;
   logic             accept, pop;
   logic [GAIN_W-1:0] gain;
   logic signed [SAMPLE_W-1:0] out_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_up    <= STEP_UP_RESET;
         cfg_ff.step_down  <= STEP_DOWN_RESET;
         cfg_ff.gain_floor <= GAIN_FLOOR_RESET;
         cfg_ff.volume_q10 <= VOLUME_RESET;
         cfg_ff.bypass     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_UP:    cfg_ff.step_up    <= csr_wdata[STEP_W-1:0];
            CSR_STEP_DOWN:  cfg_ff.step_down  <= csr_wdata[STEP_W-1:0];
            CSR_GAIN_FLOOR: cfg_ff.gain_floor <= csr_wdata[STEP_W-1:0];
            CSR_VOLUME:     cfg_ff.volume_q10 <= csr_wdata[VOLUME_W-1:0];
            CSR_BYPASS:     cfg_ff.bypass     <= csr_wdata[0];
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   fedg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .sample_in   ($signed(req_tdata)),
      .duck        (req_tuser[0]),
      .frame_start (req_tuser[1]),
      .entry       (push_entry),
      .gain        (gain)
   );

   fedg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   fedg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .head_valid   (!q_status.empty),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_sample   (out_sample),
      .out_vol_used (rsp_tuser),
      .status       (b_status)
   );

   assign rsp_tdata = out_sample;

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain <= GAIN_UNITY)
      else $error("duck gain above unity");

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      b_status.s1_valid && rsp_tvalid && !rsp_tready |=> b_status.s1_valid)
      else $error("gain stage item lost under output stall");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty && !b_status.s1_valid |-> pop)
      else $error("queue head not drained into empty gain stage");

endmodule

// ----- bench/tb_far_end_duck_gain_with_volume.sv -----
// Self-checking bench for far_end_duck_gain_with_volume: queued PCM items drive req_*, a
// clocked predictor of the duck gain and volume stages checks every rsp_* item.
// Depends on fedg_pkg and the RTL top level only.
module tb_far_end_duck_gain_with_volume;
   timeunit 1ns;
   timeprecision 1ps;
   import fedg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       duck;
      logic                       frame_start;
   } pcm_req_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       volume_used;
   } pcm_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   pcm_req_type pcm_backlog[$];
   pcm_rsp_type awaited_pcm[$];
   pcm_req_type next_req;
   pcm_req_type taken_req;
   pcm_rsp_type want;

   int items_queued = 0;
   int items_taken = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_pct = 0;
   int req_gap = 0;
   int rsp_hold = 0;

   logic [GAIN_W-1:0] gain_q15;
   logic              vol_latched;
   cfg_type           cfg;

   far_end_duck_gain_with_volume u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic pcm_rsp_type duck_and_scale(pcm_req_type item);
      logic signed [31:0]         prod;
      logic signed [SAMPLE_W-1:0] gained;
      longint                     scaled;
      int                         gain_next;
      pcm_rsp_type                res;
      gained = item.sample;
      gain_next = int'(gain_q15);
      if (item.frame_start)
         vol_latched = cfg.bypass || !item.duck || (cfg.gain_floor < gain_q15);
      if (!cfg.bypass) begin
         if (item.duck) begin
            prod = item.sample * $signed({1'b0, gain_q15});
            gained = SAMPLE_W'(prod >>> GAIN_FRAC);
            if (cfg.gain_floor < gain_q15) begin
               gain_next = int'(gain_q15) - int'(cfg.step_down);
               if (gain_next <= int'(cfg.gain_floor))
                  gain_next = int'(cfg.gain_floor);
            end
         end else if (gain_q15 != GAIN_UNITY) begin
            prod = item.sample * $signed({1'b0, gain_q15});
            gained = SAMPLE_W'(prod >>> GAIN_FRAC);
            gain_next = int'(gain_q15) + int'(cfg.step_up);
            if (gain_next > int'(GAIN_UNITY))
               gain_next = int'(GAIN_UNITY);
         end
         gain_q15 = gain_next[GAIN_W-1:0];
      end
      res.sample = gained;
      if (vol_latched) begin
         scaled = (longint'(gained) * longint'(cfg.volume_q10)) >>> VOL_FRAC;
         if (scaled > longint'(SAMPLE_MAX))
            res.sample = SAMPLE_MAX;
         else if (scaled < longint'(SAMPLE_MIN))
            res.sample = SAMPLE_MIN;
         else
            res.sample = scaled[SAMPLE_W-1:0];
      end
      res.volume_used = vol_latched;
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            req_gap = $urandom_range(0, 6);
            req_tvalid <= 1'b0;
         end else if (pcm_backlog.size() != 0) begin
            next_req = pcm_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_req.sample;
            req_tuser <= {next_req.frame_start, next_req.duck};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
         rsp_hold = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         gain_q15 = '0;
         vol_latched = 1'b0;
         cfg.step_up = STEP_UP_RESET;
         cfg.step_down = STEP_DOWN_RESET;
         cfg.gain_floor = GAIN_FLOOR_RESET;
         cfg.volume_q10 = VOLUME_RESET;
         cfg.bypass = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_STEP_UP:    cfg.step_up = csr_wdata[STEP_W-1:0];
               CSR_STEP_DOWN:  cfg.step_down = csr_wdata[STEP_W-1:0];
               CSR_GAIN_FLOOR: cfg.gain_floor = csr_wdata[STEP_W-1:0];
               CSR_VOLUME:     cfg.volume_q10 = csr_wdata;
               CSR_BYPASS:     cfg.bypass = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_pcm.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected item: sample_out %0d volume_used %0b",
                           $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = awaited_pcm.pop_front();
               if (rsp_tdata !== want.sample || rsp_tuser !== want.volume_used) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch: sample_out exp %0d got %0d, volume_used exp %0b got %0b",
                              want.sample, $signed(rsp_tdata), want.volume_used, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            taken_req.sample = req_tdata;
            taken_req.duck = req_tuser[0];
            taken_req.frame_start = req_tuser[1];
            awaited_pcm.push_back(duck_and_scale(taken_req));
            items_taken++;
         end
      end
   end

   task automatic queue_pcm(input logic [15:0] sample, input logic duck, input logic fs);
      pcm_req_type item;
      item.sample = sample;
      item.duck = duck;
      item.frame_start = fs;
      pcm_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (items_taken != items_queued || awaited_pcm.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_settings(input logic [14:0] up, input logic [14:0] down,
                                input logic [14:0] gfloor, input logic [15:0] vol,
                                input logic byp);
      settle();
      write_reg(CSR_STEP_UP, {1'b0, up});
      write_reg(CSR_STEP_DOWN, {1'b0, down});
      write_reg(CSR_GAIN_FLOOR, {1'b0, gfloor});
      write_reg(CSR_VOLUME, vol);
      write_reg(CSR_BYPASS, {15'd0, byp});
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [14:0] pick_step();
      case ($urandom_range(5))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'd1;
         3, 4:    return 15'($urandom_range(1, 2048));
         default: return 15'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic logic [14:0] pick_floor();
      case ($urandom_range(4))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'($urandom_range(0, 4096));
         default: return 15'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic logic [15:0] pick_volume();
      case ($urandom_range(4))
         0:       return 16'd0;
         1:       return 16'd1024;
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(0, 2048));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_frames(input int count);
      int  len;
      int  sent;
      logic duck;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            queue_pcm(pick_sample(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            len = $urandom_range(1, 24);
            duck = 1'($urandom_range(1));
            for (int k = 0; k < len; k++) begin
               if (k != 0 && $urandom_range(15) == 0)
                  duck = ~duck;
               queue_pcm(pick_sample(), duck, k == 0);
            end
            sent += len;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      stall_pct = 20;
      load_settings(15'h4000, 15'h3000, 15'h0800, 16'hFFFF, 1'b0);
      queue_pcm(16'h8000, 1'b1, 1'b1);
      queue_pcm(16'h7FFF, 1'b0, 1'b1);
      queue_pcm(16'h7FFF, 1'b0, 1'b0);
      queue_pcm(16'h8000, 1'b0, 1'b0);
      queue_pcm(16'd1234, 1'b0, 1'b1);
      queue_pcm(16'hFFFF, 1'b1, 1'b1);
      queue_pcm(16'h8000, 1'b1, 1'b0);
      queue_pcm(16'd100, 1'b1, 1'b0);
      queue_pcm(16'd100, 1'b1, 1'b1);
      queue_pcm(16'hFFFB, 1'b1, 1'b0);

      load_settings(15'h4000, 15'h3000, 15'h0800, 16'd1, 1'b1);
      queue_pcm(16'h8000, 1'b1, 1'b1);
      queue_pcm(16'h7FFF, 1'b0, 1'b0);
      queue_pcm(16'hFFFF, 1'b1, 1'b0);
      queue_pcm(16'd5, 1'b0, 1'b1);

      load_settings(15'd0, 15'd0, 15'd0, 16'd0, 1'b0);
      queue_pcm(16'd1000, 1'b1, 1'b1);
      queue_pcm(16'hFC18, 1'b0, 1'b0);
      queue_pcm(16'h7FFF, 1'b1, 1'b1);

      load_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 16'd1024, 1'b0);
      queue_pcm(16'h8000, 1'b0, 1'b1);
      queue_pcm(16'h8000, 1'b0, 1'b0);
      queue_pcm(16'h7FFF, 1'b1, 1'b1);
      queue_pcm(16'h8000, 1'b1, 1'b0);

      for (int p = 0; p < 7; p++) begin
         load_settings(pick_step(), pick_step(), pick_floor(), pick_volume(),
                       $urandom_range(4) == 0);
         stall_pct = (p == 6) ? 0 : $urandom_range(0, 40);
         queue_frames(105);
      end

      settle();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/fedg_pkg.sv
hw/rtl/fedg_front.sv
hw/rtl/fedg_queue.sv
hw/rtl/fedg_back.sv
hw/rtl/far_end_duck_gain_with_volume.sv
bench/tb_far_end_duck_gain_with_volume.sv
